@@ sv/ezr_pkg.sv @@
// Shared types, constants and arithmetic helpers for the ZYX Euler rotation matrix block.
package ezr_pkg;

	localparam int NUM_STEPS = 18;
	localparam int LATENCY   = 23;

	typedef logic signed [33:0] xy_t;
	typedef logic signed [24:0] ang_t;
	typedef logic signed [21:0] sc_t;
	typedef logic signed [43:0] prod_t;
	typedef logic signed [44:0] part_t;
	typedef logic signed [63:0] wide_t;
	typedef logic signed [15:0] q14_t;

	// One rotation in flight: vector, residual angle and quadrant.
	typedef struct packed {
		xy_t        x;
		xy_t        y;
		ang_t       z;
		logic [1:0] quad;
	} rot_t;

	localparam xy_t  CORDIC_GAIN = 34'sd652032874;

	localparam ang_t ATAN_TBL [0:NUM_STEPS-1] = '{
		25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050, 25'sd166669,
		25'sd83416, 25'sd41718, 25'sd20860, 25'sd10430, 25'sd5215,
		25'sd2608, 25'sd1304, 25'sd652, 25'sd326, 25'sd163,
		25'sd81, 25'sd41, 25'sd20
	};

	// Q3.30 to Q1.20, rounded half up and clamped to plus or minus one.
	function automatic sc_t to_sc(input xy_t v);
		xy_t t;
		t = (v + 34'sd512) >>> 10;
		if (t > 34'sd1048576) begin
			t = 34'sd1048576;
		end else if (t < -34'sd1048576) begin
			t = -34'sd1048576;
		end
		return t[21:0];
	endfunction

	// Q60 sum to Q2.14, rounded half up and saturated to plus or minus one.
	function automatic q14_t to_q14(input wide_t s);
		wide_t t;
		t = (s + (64'sd1 <<< 45)) >>> 46;
		if (t > 64'sd16384) begin
			t = 64'sd16384;
		end else if (t < -64'sd16384) begin
			t = -64'sd16384;
		end
		return t[15:0];
	endfunction

endpackage

@@ sv/euler_zyx_rotation_matrix.sv @@
// Top level: ZYX Euler angles to a Q2.14 rotation matrix through a chain of CORDIC cells.
//
//   Channel   Signals                                 Direction  Handshake
//   -------   -------------------------------------   ---------  ------------------------
//   angles    roll_angle, pitch_angle, yaw_angle      in         start high, busy low
//   matrix    m00 m01 m02 m10 m11 m12 m20 m21 m22     out        done strobe, one cycle
//
// One item may be started in every clock cycle; busy never rises.
// Each matrix passes through 18 CORDIC cells, one quadrant and rounding
// stage, two multiplier stages, one sum stage and the output register.
// The done strobe lasts exactly one cycle per item.
// Reset clears only the valid bits that travel with the items; data holds no reset.
// The receiver cannot stall the block, so the pipeline never stops.
//
// Sine and cosine of each angle come from an 18-step CORDIC run on the low 14
// bits of the binary angle; the top two bits pick the quadrant, applied after
// the last cell by swapping and negating the vector. Each cell performs one
// step for all three angles at once and passes its vector, residual angle and
// quadrant to the next cell on the following edge. The products that form the
// nine entries are exact in Q60, so rounding to Q2.14 happens only once.
module euler_zyx_rotation_matrix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [15:0]   roll_angle,
	input  logic signed [15:0]   pitch_angle,
	input  logic signed [15:0]   yaw_angle,
	output logic                 done,
	output logic signed [15:0]   m00,
	output logic signed [15:0]   m01,
	output logic signed [15:0]   m02,
	output logic signed [15:0]   m10,
	output logic signed [15:0]   m11,
	output logic signed [15:0]   m12,
	output logic signed [15:0]   m20,
	output logic signed [15:0]   m21,
	output logic signed [15:0]   m22
);

	logic [15:0]     angles [3];
	ezr_pkg::rot_t   chain_rot [ezr_pkg::NUM_STEPS+1][3];
	logic            chain_vld [ezr_pkg::NUM_STEPS+1];
	ezr_pkg::q14_t   ent [9];

	// The block has no stall condition.
	assign busy = 1'b0;

	assign angles[0] = roll_angle;
	assign angles[1] = pitch_angle;
	assign angles[2] = yaw_angle;

	// Seed of the first cell: the angle within its quadrant in units of 2^-24 turn.
	for (genvar k = 0; k < 3; k++) begin : g_seed
		assign chain_rot[0][k] = {ezr_pkg::CORDIC_GAIN, 34'sd0,
		                          {3'b000, angles[k][13:0], 8'h00}, angles[k][15:14]};
	end
	assign chain_vld[0] = start & ~busy;

	for (genvar i = 0; i < ezr_pkg::NUM_STEPS; i++) begin : g_cell
		ezr_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_vld[i]),
			.in_rot    (chain_rot[i]),
			.out_valid (chain_vld[i+1]),
			.out_rot   (chain_rot[i+1])
		);
	end

	ezr_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_vld[ezr_pkg::NUM_STEPS]),
		.in_rot    (chain_rot[ezr_pkg::NUM_STEPS]),
		.out_valid (done),
		.ent       (ent)
	);

	assign m00 = ent[0];
	assign m01 = ent[1];
	assign m02 = ent[2];
	assign m10 = ent[3];
	assign m11 = ent[4];
	assign m12 = ent[5];
	assign m20 = ent[6];
	assign m21 = ent[7];
	assign m22 = ent[8];

endmodule

@@ sv/ezr_cordic_cell.sv @@
// One CORDIC rotation step for the three angles, registered.
module ezr_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ezr_pkg::rot_t   in_rot [3],
	output logic            out_valid,
	output ezr_pkg::rot_t   out_rot [3]
);

	ezr_pkg::rot_t nxt [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].quad = in_rot[k].quad;
			if (!in_rot[k].z[24]) begin
				nxt[k].x = in_rot[k].x - (in_rot[k].y >>> STEP);
				nxt[k].y = in_rot[k].y + (in_rot[k].x >>> STEP);
				nxt[k].z = in_rot[k].z - ezr_pkg::ATAN_TBL[STEP];
			end else begin
				nxt[k].x = in_rot[k].x + (in_rot[k].y >>> STEP);
				nxt[k].y = in_rot[k].y - (in_rot[k].x >>> STEP);
				nxt[k].z = in_rot[k].z + ezr_pkg::ATAN_TBL[STEP];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_rot <= nxt;
	end

endmodule

@@ sv/ezr_matrix.sv @@
// Quadrant fold, sine and cosine rounding, and the products that form the nine entries.
module ezr_matrix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ezr_pkg::rot_t   in_rot [3],
	output logic            out_valid,
	output ezr_pkg::q14_t   ent [9]
);

	// Stage 1: sine and cosine per angle (0 roll, 1 pitch, 2 yaw).
	ezr_pkg::sc_t  s_s1 [3];
	ezr_pkg::sc_t  c_s1 [3];
	logic          v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			case (in_rot[k].quad)
				2'd1: begin
					c_s1[k] <= ezr_pkg::to_sc(-in_rot[k].y);
					s_s1[k] <= ezr_pkg::to_sc(in_rot[k].x);
				end
				2'd2: begin
					c_s1[k] <= ezr_pkg::to_sc(-in_rot[k].x);
					s_s1[k] <= ezr_pkg::to_sc(-in_rot[k].y);
				end
				2'd3: begin
					c_s1[k] <= ezr_pkg::to_sc(in_rot[k].y);
					s_s1[k] <= ezr_pkg::to_sc(-in_rot[k].x);
				end
				default: begin
					c_s1[k] <= ezr_pkg::to_sc(in_rot[k].x);
					s_s1[k] <= ezr_pkg::to_sc(in_rot[k].y);
				end
			endcase
		end
	end

	// Stage 2: two-factor products in Q40.
	ezr_pkg::prod_t spsr_s2, spcr_s2, cycp_s2, sycp_s2, sycr_s2;
	ezr_pkg::prod_t sysr_s2, cycr_s2, cysr_s2, cpsr_s2, cpcr_s2;
	ezr_pkg::sc_t   sp_s2, cy_s2, sy_s2;

	always_ff @(posedge clk) begin
		spsr_s2 <= ezr_pkg::prod_t'(s_s1[1]) * ezr_pkg::prod_t'(s_s1[0]);
		spcr_s2 <= ezr_pkg::prod_t'(s_s1[1]) * ezr_pkg::prod_t'(c_s1[0]);
		cycp_s2 <= ezr_pkg::prod_t'(c_s1[2]) * ezr_pkg::prod_t'(c_s1[1]);
		sycp_s2 <= ezr_pkg::prod_t'(s_s1[2]) * ezr_pkg::prod_t'(c_s1[1]);
		sycr_s2 <= ezr_pkg::prod_t'(s_s1[2]) * ezr_pkg::prod_t'(c_s1[0]);
		sysr_s2 <= ezr_pkg::prod_t'(s_s1[2]) * ezr_pkg::prod_t'(s_s1[0]);
		cycr_s2 <= ezr_pkg::prod_t'(c_s1[2]) * ezr_pkg::prod_t'(c_s1[0]);
		cysr_s2 <= ezr_pkg::prod_t'(c_s1[2]) * ezr_pkg::prod_t'(s_s1[0]);
		cpsr_s2 <= ezr_pkg::prod_t'(c_s1[1]) * ezr_pkg::prod_t'(s_s1[0]);
		cpcr_s2 <= ezr_pkg::prod_t'(c_s1[1]) * ezr_pkg::prod_t'(c_s1[0]);
		sp_s2   <= s_s1[1];
		cy_s2   <= c_s1[2];
		sy_s2   <= s_s1[2];
	end

	// Stage 3: three-factor products split into high and low partial products.
	logic signed [22:0] spsr_hi, spcr_hi;
	logic signed [21:0] spsr_lo, spcr_lo;
	ezr_pkg::part_t cyA_hi_s3, cyA_lo_s3, cyB_hi_s3, cyB_lo_s3;
	ezr_pkg::part_t syA_hi_s3, syA_lo_s3, syB_hi_s3, syB_lo_s3;
	ezr_pkg::prod_t cycp_s3, sycp_s3, sycr_s3, sysr_s3, cycr_s3, cysr_s3, cpsr_s3, cpcr_s3;
	ezr_pkg::sc_t   sp_s3;

	assign spsr_hi = spsr_s2[43:21];
	assign spcr_hi = spcr_s2[43:21];
	assign spsr_lo = {1'b0, spsr_s2[20:0]};
	assign spcr_lo = {1'b0, spcr_s2[20:0]};

	always_ff @(posedge clk) begin
		cyA_hi_s3 <= ezr_pkg::part_t'(cy_s2) * ezr_pkg::part_t'(spsr_hi);
		cyA_lo_s3 <= ezr_pkg::part_t'(cy_s2) * ezr_pkg::part_t'(spsr_lo);
		cyB_hi_s3 <= ezr_pkg::part_t'(cy_s2) * ezr_pkg::part_t'(spcr_hi);
		cyB_lo_s3 <= ezr_pkg::part_t'(cy_s2) * ezr_pkg::part_t'(spcr_lo);
		syA_hi_s3 <= ezr_pkg::part_t'(sy_s2) * ezr_pkg::part_t'(spsr_hi);
		syA_lo_s3 <= ezr_pkg::part_t'(sy_s2) * ezr_pkg::part_t'(spsr_lo);
		syB_hi_s3 <= ezr_pkg::part_t'(sy_s2) * ezr_pkg::part_t'(spcr_hi);
		syB_lo_s3 <= ezr_pkg::part_t'(sy_s2) * ezr_pkg::part_t'(spcr_lo);
		cycp_s3   <= cycp_s2;
		sycp_s3   <= sycp_s2;
		sycr_s3   <= sycr_s2;
		sysr_s3   <= sysr_s2;
		cycr_s3   <= cycr_s2;
		cysr_s3   <= cysr_s2;
		cpsr_s3   <= cpsr_s2;
		cpcr_s3   <= cpcr_s2;
		sp_s3     <= sp_s2;
	end

	// Stage 4: exact sums in Q60.
	ezr_pkg::wide_t cysprs, cyspcr, sysprs, syspcr;
	ezr_pkg::wide_t sum_s4 [9];

	assign cysprs = (ezr_pkg::wide_t'(cyA_hi_s3) <<< 21) + ezr_pkg::wide_t'(cyA_lo_s3);
	assign cyspcr = (ezr_pkg::wide_t'(cyB_hi_s3) <<< 21) + ezr_pkg::wide_t'(cyB_lo_s3);
	assign sysprs = (ezr_pkg::wide_t'(syA_hi_s3) <<< 21) + ezr_pkg::wide_t'(syA_lo_s3);
	assign syspcr = (ezr_pkg::wide_t'(syB_hi_s3) <<< 21) + ezr_pkg::wide_t'(syB_lo_s3);

	always_ff @(posedge clk) begin
		sum_s4[0] <= ezr_pkg::wide_t'(cycp_s3) <<< 20;
		sum_s4[1] <= cysprs - (ezr_pkg::wide_t'(sycr_s3) <<< 20);
		sum_s4[2] <= cyspcr + (ezr_pkg::wide_t'(sysr_s3) <<< 20);
		sum_s4[3] <= ezr_pkg::wide_t'(sycp_s3) <<< 20;
		sum_s4[4] <= sysprs + (ezr_pkg::wide_t'(cycr_s3) <<< 20);
		sum_s4[5] <= syspcr - (ezr_pkg::wide_t'(cysr_s3) <<< 20);
		sum_s4[6] <= -(ezr_pkg::wide_t'(sp_s3) <<< 40);
		sum_s4[7] <= ezr_pkg::wide_t'(cpsr_s3) <<< 20;
		sum_s4[8] <= ezr_pkg::wide_t'(cpcr_s3) <<< 20;
	end

	// Stage 5: round and saturate into the output register.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			ent[k] <= ezr_pkg::to_q14(sum_s4[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

endmodule

@@ sv/ezr_checker.sv @@
// Port-level checks on the rotation matrix block, bound to the top level.
module ezr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] m00,
	input logic signed [15:0] m20,
	input logic signed [15:0] m22
);

	// Every taken item yields its matrix after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ezr_pkg::LATENCY) done)
		else $error("matrix missing after item was taken");

	// No matrix appears without an item taken the fixed latency before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ezr_pkg::LATENCY))
		else $error("matrix strobe without a matching item");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised by a block that never stalls");

	// Entries stay within plus or minus one in Q2.14.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (m00 <= 16'sd16384 && m00 >= -16'sd16384 &&
		          m20 <= 16'sd16384 && m20 >= -16'sd16384 &&
		          m22 <= 16'sd16384 && m22 >= -16'sd16384))
		else $error("matrix entry outside plus or minus one");

endmodule

bind euler_zyx_rotation_matrix ezr_checker u_ezr_checker (.*);
